@@ src/sva_pkg.sv @@
package sva_pkg;

  // Build-time defaults
  localparam int MAX_CHAN_DEF = 32;

  // Field widths
  localparam int OP_W     = 3;
  localparam int ORIGIN_W = 16;
  localparam int CLASS_W  = 3;
  localparam int PRI_W    = 8;
  localparam int IDX_W    = 5;
  localparam int STAT_W   = 3;
  localparam int ACT_W    = 6;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 8;
  localparam int CFG_A_W  = 1;

  // Channel entry held in RAM: {origin, class, priority}
  localparam int ENT_W = ORIGIN_W + CLASS_W + PRI_W;

  // Common width for comparing counts and indexes
  localparam int CMP_W = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DETACH  = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
  localparam logic [OP_W-1:0] OP_SETPRI  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_FREE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STAT_W-1:0] ST_EVICTED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_ACTIVE = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_SFX    = 1'd1;

  // Reset value of the active-channels configuration register
  localparam logic [ACT_W-1:0] ACTIVE_RST = 6'd8;

  // Outcome flags of one table scan
  typedef struct packed {
    logic found_match;
    logic found_free;
    logic have_max;
  } sva_scan_flags_t;

endpackage

@@ src/sound_voice_allocator.sv @@
// Channel        Dir  Beat contents
// s_axis_*       in   opcode, origin_id, sound_class, priority_req, channel_index
// m_axis_*       out  status, channel (one beat per input beat)
// cfg_*          in   write enable, register index, data (no read-back)
//
// Allocate, stop and detach scan the active channels (active_channels capped
// at MAX_CHAN) one RAM read per cycle; the result is then formed in the final
// state, and the next beat is taken once it is in the output register.
// With a count of zero the scan is skipped. Set priority does a single
// read-modify-write; release, clear all and ignored beats go straight to the
// final state. Reset and clear all drop every valid bit at once, so no
// clearing pass is needed. A new result waits in the final state while the
// previous one is still unclaimed; once it sits in the output register the
// next input beat is taken meanwhile.
module sound_voice_allocator import sva_pkg::*; #(
  parameter int MAX_CHAN = MAX_CHAN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // [2:0] opcode, [18:3] origin_id, [21:19] sound_class,
  // [29:22] priority_req, [34:30] channel_index, [39:35] zero
  input  logic [IN_W-1:0]    s_axis_tdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [2:0] status, [7:3] channel
  output logic [OUT_W-1:0]   m_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [ACT_W-1:0]   cfg_data
);

  localparam int IW = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
  localparam int CW = $clog2(MAX_CHAN + 1);
  localparam logic [CMP_W-1:0] MAX_CHAN_C = CMP_W'(MAX_CHAN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Configuration registers
  logic [ACT_W-1:0] active_channels;
  logic             sfx_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= ACTIVE_RST;
      sfx_enable      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ACTIVE: active_channels <= cfg_data;
        CFG_SFX:    sfx_enable      <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Channel table: valid and detached bits in flops, the rest in RAM
  logic [MAX_CHAN-1:0] chan_valid;
  logic [MAX_CHAN-1:0] chan_det;
  logic [ENT_W-1:0]    chan_ram [MAX_CHAN];
  logic [ENT_W-1:0]    ram_rd;

  logic [1:0] state;
  logic [1:0] state_next;

  // Latched request
  logic [OP_W-1:0]     op;
  logic [ORIGIN_W-1:0] org;
  logic [CLASS_W-1:0]  cls;
  logic [PRI_W-1:0]    pri;
  logic [IW-1:0]       idx;
  logic [CMP_W-1:0]    idx_x;
  logic [CMP_W-1:0]    n_cnt;
  logic                ign;

  // Scan control
  logic [CW-1:0] scan_addr;
  logic [CW-1:0] scan_end;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic          issue;

  // Decode of the incoming beat
  logic                in_acc;
  logic [OP_W-1:0]     in_op;
  logic [IDX_W-1:0]    in_idx;
  logic [CMP_W-1:0]    in_idx_x;
  logic [IW-1:0]       in_idx_i;
  logic [CMP_W-1:0]    act_x;
  logic [CMP_W-1:0]    in_n;
  logic                in_ign;
  logic                in_scan;
  logic                in_setpri;

  always_comb begin
    in_acc    = s_axis_tvalid && s_axis_tready;
    in_op     = s_axis_tdata[2:0];
    in_idx    = s_axis_tdata[34:30];
    in_idx_x  = CMP_W'(in_idx);
    in_idx_i  = in_idx_x[IW-1:0];
    act_x     = CMP_W'(active_channels);
    in_n      = (act_x > MAX_CHAN_C) ? MAX_CHAN_C : act_x;
    in_ign    = !sfx_enable &&
                ((in_op == OP_ALLOC) || (in_op == OP_STOP) || (in_op == OP_DETACH));
    in_scan   = !in_ign && (in_n != '0) &&
                ((in_op == OP_ALLOC) || (in_op == OP_STOP) || (in_op == OP_DETACH));
    in_setpri = (in_op == OP_SETPRI) && (in_idx_x < in_n) && chan_valid[in_idx_i];
  end

  assign s_axis_tready = (state == S_IDLE);
  assign issue         = (scan_addr != scan_end);

  // Scan over the table
  sva_scan_flags_t     flags;
  logic [IW-1:0]       match_idx;
  logic [IW-1:0]       free_idx;
  logic [IW-1:0]       max_idx;
  logic [PRI_W-1:0]    max_pri;
  logic                scan_hit;

  assign scan_hit = (state == S_SCAN) && rd_pend;

  sva_scan #(.IW(IW)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (in_acc),
    .hit         (scan_hit),
    .idx         (rd_idx),
    .ent_valid   (chan_valid[rd_idx]),
    .ent_det     (chan_det[rd_idx]),
    .ent_origin  (ram_rd[ENT_W-1 -: ORIGIN_W]),
    .ent_class   (ram_rd[PRI_W +: CLASS_W]),
    .ent_pri     (ram_rd[PRI_W-1:0]),
    .req_origin  (org),
    .req_class   (cls),
    .match_class (op == OP_ALLOC),
    .flags       (flags),
    .match_idx   (match_idx),
    .free_idx    (free_idx),
    .max_idx     (max_idx),
    .max_pri     (max_pri)
  );

  // Final decision, table update and result
  logic               fin_go;
  logic               setpri_ok;
  logic [STAT_W-1:0]  res_status;
  logic [IW-1:0]      res_ch;
  logic               wr_en;
  logic [ENT_W-1:0]   wr_data;
  logic               set_valid;
  logic               clr_valid;
  logic               set_det;
  logic               clr_all;
  logic [CMP_W-1:0]   res_ch_x;

  always_comb begin
    fin_go     = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);
    setpri_ok  = (idx_x < n_cnt) && chan_valid[idx];
    res_status = ST_NONE;
    res_ch     = '0;
    wr_en      = 1'b0;
    wr_data    = {org, cls, pri};
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    set_det    = 1'b0;
    clr_all    = 1'b0;
    if (ign) begin
      res_status = ST_NONE;
    end else begin
      case (op)
        OP_ALLOC: begin
          if (flags.found_match) begin
            res_status = ST_REPLACED;
            res_ch     = match_idx;
          end else if (flags.found_free) begin
            res_status = ST_FREE;
            res_ch     = free_idx;
          end else if (flags.have_max && (pri <= max_pri)) begin
            res_status = ST_EVICTED;
            res_ch     = max_idx;
          end else begin
            res_status = ST_REJECTED;
          end
          if (res_status != ST_REJECTED) begin
            wr_en     = 1'b1;
            set_valid = 1'b1;
          end
        end
        OP_STOP: begin
          if (flags.found_match) begin
            res_status = ST_DONE;
            res_ch     = match_idx;
            clr_valid  = 1'b1;
          end
        end
        OP_DETACH: begin
          if (flags.found_match) begin
            res_status = ST_DONE;
            res_ch     = match_idx;
            set_det    = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (setpri_ok) begin
            res_status = ST_DONE;
            res_ch     = idx;
            clr_valid  = 1'b1;
          end
        end
        OP_SETPRI: begin
          if (setpri_ok) begin
            res_status = ST_DONE;
            res_ch     = idx;
            wr_en      = 1'b1;
            wr_data    = {ram_rd[ENT_W-1:PRI_W], pri};
          end
        end
        OP_CLEAR: begin
          res_status = ST_DONE;
          clr_all    = 1'b1;
        end
        default: res_status = ST_NONE;
      endcase
    end
    res_ch_x = CMP_W'(res_ch);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = (in_scan || in_setpri) ? S_SCAN : S_FIN;
      S_SCAN: if (!issue && !rd_pend) state_next = S_FIN;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request latch and scan range
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op    <= in_op;
      org   <= s_axis_tdata[18:3];
      cls   <= s_axis_tdata[21:19];
      pri   <= s_axis_tdata[29:22];
      idx   <= in_idx_i;
      idx_x <= in_idx_x;
      n_cnt <= in_n;
      ign   <= in_ign;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      scan_end  <= '0;
      rd_pend   <= 1'b0;
    end else if (in_acc) begin
      rd_pend <= 1'b0;
      if (in_setpri) begin
        scan_addr <= CW'(in_idx_x);
        scan_end  <= CW'(in_idx_x) + CW'(1);
      end else if (in_scan) begin
        scan_addr <= '0;
        scan_end  <= CW'(in_n);
      end else begin
        scan_addr <= '0;
        scan_end  <= '0;
      end
    end else if (state == S_SCAN) begin
      rd_pend <= issue;
      if (issue) scan_addr <= scan_addr + CW'(1);
    end
  end

  // Channel RAM: one read, one write port
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && issue) begin
      ram_rd <= chan_ram[scan_addr[IW-1:0]];
      rd_idx <= scan_addr[IW-1:0];
    end
    if (fin_go && wr_en) chan_ram[res_ch] <= wr_data;
  end

  // Valid and detached bits
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= '0;
      chan_det   <= '0;
    end else if (fin_go) begin
      if (clr_all) begin
        chan_valid <= '0;
        chan_det   <= '0;
      end else begin
        if (set_valid) begin
          chan_valid[res_ch] <= 1'b1;
          chan_det[res_ch]   <= 1'b0;
        end
        if (clr_valid) begin
          chan_valid[res_ch] <= 1'b0;
          chan_det[res_ch]   <= 1'b0;
        end
        if (set_det) chan_det[res_ch] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) m_axis_tdata <= {res_ch_x[IDX_W-1:0], res_status};
  end

endmodule

@@ src/sva_scan.sv @@
module sva_scan import sva_pkg::*; #(
  parameter int IW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                hit,
  input  logic [IW-1:0]       idx,
  input  logic                ent_valid,
  input  logic                ent_det,
  input  logic [ORIGIN_W-1:0] ent_origin,
  input  logic [CLASS_W-1:0]  ent_class,
  input  logic [PRI_W-1:0]    ent_pri,
  input  logic [ORIGIN_W-1:0] req_origin,
  input  logic [CLASS_W-1:0]  req_class,
  input  logic                match_class,
  output sva_scan_flags_t     flags,
  output logic [IW-1:0]       match_idx,
  output logic [IW-1:0]       free_idx,
  output logic [IW-1:0]       max_idx,
  output logic [PRI_W-1:0]    max_pri
);

  logic is_match;
  logic is_free;
  logic is_max;

  // Classify the entry coming out of the RAM this cycle
  always_comb begin
    is_match = ent_valid && !ent_det && (ent_origin == req_origin) &&
               (!match_class || (ent_class == req_class));
    is_free  = !ent_valid;
    // strict compare: the first of equal priorities wins
    is_max   = ent_valid && (!flags.have_max || (ent_pri > max_pri));
  end

  // Flags: first match, first free, busiest-to-evict
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else if (hit) begin
      if (is_match) flags.found_match <= 1'b1;
      if (is_free)  flags.found_free  <= 1'b1;
      if (is_max)   flags.have_max    <= 1'b1;
    end
  end

  // Captured indexes and running maximum
  always_ff @(posedge clk) begin
    if (hit) begin
      if (is_match && !flags.found_match) match_idx <= idx;
      if (is_free && !flags.found_free)   free_idx  <= idx;
      if (is_max) begin
        max_idx <= idx;
        max_pri <= ent_pri;
      end
    end
  end

endmodule

@@ sim/sva_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, result and register-write channels of the voice
// allocator, keeps its own copy of the channel table and checks every
// result beat against the grant it predicts.
module sva_checker import sva_pkg::*; #(
  parameter int MAX_CHAN = MAX_CHAN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [IN_W-1:0]    s_axis_tdata,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [ACT_W-1:0]   cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen
);

  // Bit offsets of the request fields
  localparam int ORG_LSB = OP_W;
  localparam int CLS_LSB = ORG_LSB + ORIGIN_W;
  localparam int PRI_LSB = CLS_LSB + CLASS_W;
  localparam int IDX_LSB = PRI_LSB + PRI_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  channel;
  } grant_t;

  // Shadow channel table and registers
  logic                ch_busy     [MAX_CHAN];
  logic [ORIGIN_W-1:0] ch_origin   [MAX_CHAN];
  logic [CLASS_W-1:0]  ch_class    [MAX_CHAN];
  logic [PRI_W-1:0]    ch_pri      [MAX_CHAN];
  logic                ch_detached [MAX_CHAN];
  logic [ACT_W-1:0]    cfg_active;
  logic                cfg_sfx;

  grant_t grant_q [$];

  function automatic void drop_channel(input int i);
    ch_busy[i]     = 1'b0;
    ch_origin[i]   = '0;
    ch_class[i]    = '0;
    ch_pri[i]      = '0;
    ch_detached[i] = 1'b0;
  endfunction

  // Apply one request to the shadow table and return the grant it yields
  function automatic grant_t voice_table_step(input logic [IN_W-1:0] beat);
    logic [OP_W-1:0]     op;
    logic [ORIGIN_W-1:0] org;
    logic [CLASS_W-1:0]  cls;
    logic [PRI_W-1:0]    pri;
    logic [IDX_W-1:0]    idx;
    int                  n;
    int                  i;
    int                  hit;
    int                  worst_pri;
    int                  worst_idx;
    grant_t              g;
    op  = beat[OP_W-1:0];
    org = beat[ORG_LSB +: ORIGIN_W];
    cls = beat[CLS_LSB +: CLASS_W];
    pri = beat[PRI_LSB +: PRI_W];
    idx = beat[IDX_LSB +: IDX_W];
    n   = (cfg_active > MAX_CHAN) ? MAX_CHAN : int'(cfg_active);
    g.status  = ST_NONE;
    g.channel = '0;
    hit = -1;
    // allocate, stop and detach are dropped while sound effects are off
    if (op > OP_DETACH || cfg_sfx) begin
      case (op)
        OP_ALLOC: begin
          for (i = 0; i < n; i++) begin
            if (ch_busy[i] && !ch_detached[i] && ch_origin[i] == org && ch_class[i] == cls) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            g.status = ST_REPLACED;
          end else begin
            // walk busy channels up to the first free one, tracking the worst priority
            worst_pri = -1;
            worst_idx = 0;
            for (i = 0; i < n && ch_busy[i]; i++) begin
              if (int'(ch_pri[i]) > worst_pri) begin
                worst_pri = int'(ch_pri[i]);
                worst_idx = i;
              end
            end
            if (i < n) begin
              hit = i;
              g.status = ST_FREE;
            end else if (int'(pri) > worst_pri) begin
              g.status = ST_REJECTED;
            end else begin
              hit = worst_idx;
              g.status = ST_EVICTED;
            end
          end
          if (hit >= 0) begin
            ch_busy[hit]     = 1'b1;
            ch_origin[hit]   = org;
            ch_class[hit]    = cls;
            ch_pri[hit]      = pri;
            ch_detached[hit] = 1'b0;
            g.channel = hit[IDX_W-1:0];
          end
        end
        OP_STOP, OP_DETACH: begin
          for (i = 0; i < n; i++) begin
            if (ch_busy[i] && !ch_detached[i] && ch_origin[i] == org) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            if (op == OP_STOP) drop_channel(hit);
            else ch_detached[hit] = 1'b1;
            g.status  = ST_DONE;
            g.channel = hit[IDX_W-1:0];
          end
        end
        OP_RELEASE, OP_SETPRI: begin
          if (int'(idx) < n && ch_busy[idx]) begin
            if (op == OP_RELEASE) drop_channel(int'(idx));
            else ch_pri[idx] = pri;
            g.status  = ST_DONE;
            g.channel = idx;
          end
        end
        OP_CLEAR: begin
          for (i = 0; i < MAX_CHAN; i++) drop_channel(i);
          g.status = ST_DONE;
        end
        default: ;
      endcase
    end
    return g;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Registers first, then the result beat, then the new request beat
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      for (int i = 0; i < MAX_CHAN; i++) drop_channel(i);
      cfg_active = ACTIVE_RST;
      cfg_sfx = 1'b1;
      grant_q.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_ACTIVE) cfg_active = cfg_data;
        else if (cfg_addr == CFG_SFX) cfg_sfx = cfg_data[0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tdata[STAT_W-1:0];
        got.channel = m_axis_tdata[STAT_W +: IDX_W];
        results_seen++;
        if (grant_q.size() == 0) begin
          flag_error($sformatf("result beat status=%0d channel=%0d with no request pending",
                               got.status, got.channel));
        end else begin
          want = grant_q.pop_front();
          if (got.status !== want.status || got.channel !== want.channel)
            flag_error($sformatf("result %0d: status exp %0d got %0d, channel exp %0d got %0d",
                                 results_seen, want.status, got.status,
                                 want.channel, got.channel));
        end
      end
      if (s_axis_tvalid && s_axis_tready) grant_q.push_back(voice_table_step(s_axis_tdata));
    end
    outstanding <= grant_q.size();
  end

endmodule

@@ sim/tb_sound_voice_allocator.sv @@
`timescale 1ns / 100ps

module tb_sound_voice_allocator import sva_pkg::*;;

  // Opcodes the block does not decode
  localparam logic [OP_W-1:0] OP_BAD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD7 = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  logic               clk;
  logic               rst;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [ACT_W-1:0]   cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int send_idle_pct;
  int stall_pct;
  int beats_sent;
  int settings_run;

  sound_voice_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  sva_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [IN_W-1:0] pack_beat(input logic [OP_W-1:0] op,
                                                input logic [ORIGIN_W-1:0] org,
                                                input logic [CLASS_W-1:0] cls,
                                                input logic [PRI_W-1:0] pri,
                                                input logic [IDX_W-1:0] idx);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[OP_W+ORIGIN_W+CLASS_W+PRI_W+IDX_W-1:0] = {idx, pri, cls, org, op};
    return beat;
  endfunction

  // Mostly well-formed traffic on a small set of origins so that matches,
  // replacements and evictions happen; the rest is raw noise
  function automatic logic [IN_W-1:0] random_beat(input int chans);
    logic [OP_W-1:0]     op;
    logic [ORIGIN_W-1:0] org;
    logic [CLASS_W-1:0]  cls;
    logic [IDX_W-1:0]    idx;
    int                  r;
    r = $urandom_range(99);
    if (r < 50) op = OP_ALLOC;
    else if (r < 60) op = OP_STOP;
    else if (r < 67) op = OP_DETACH;
    else if (r < 76) op = OP_RELEASE;
    else if (r < 88) op = OP_SETPRI;
    else if (r < 89) op = OP_CLEAR;
    else if (r < 93) op = $urandom_range(1) ? OP_BAD6 : OP_BAD7;
    else return pack_beat(OP_W'($urandom_range(7)), ORIGIN_W'($urandom_range(65535)),
                          CLASS_W'($urandom_range(7)), PRI_W'($urandom_range(255)),
                          IDX_W'($urandom_range(31)));
    org = ($urandom_range(99) < 75) ? ORIGIN_W'($urandom_range(7)) : ORIGIN_W'($urandom);
    cls = ($urandom_range(99) < 60) ? CLASS_W'($urandom_range(1)) : CLASS_W'($urandom_range(7));
    if (chans > 0 && $urandom_range(99) < 80) idx = IDX_W'($urandom_range(chans - 1));
    else idx = IDX_W'($urandom_range(31));
    return pack_beat(op, org, cls, PRI_W'($urandom_range(255)), idx);
  endfunction

  // Hold one request beat until the block takes it
  task automatic send_beat(input logic [IN_W-1:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [ACT_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One register setting with its own idle pattern; pauses once halfway
  task automatic run_phase(input int active, input logic sfx, input int send_pct,
                           input int stall, input int items);
    int chans;
    wait_idle();
    write_reg(CFG_ACTIVE, ACT_W'(active));
    write_reg(CFG_SFX, ACT_W'(sfx));
    settings_run++;
    send_idle_pct = send_pct;
    stall_pct = stall;
    chans = (active > MAX_CHAN_DEF) ? MAX_CHAN_DEF : active;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) wait_idle();
      send_beat(random_beat(chans));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tdata = '0;
    s_axis_tvalid = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_ACTIVE;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    settings_run = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (8 channels, effects on)
    send_beat(pack_beat(OP_RELEASE, 16'h0000, 3'd0, 8'd0, 5'd0));   // empty table
    send_beat(pack_beat(OP_SETPRI, 16'h0000, 3'd0, 8'd9, 5'd0));
    send_beat(pack_beat(OP_STOP, 16'h0000, 3'd0, 8'd0, 5'd0));
    send_beat(pack_beat(OP_ALLOC, 16'hFFFF, 3'd7, 8'd255, 5'd31));  // free slot
    send_beat(pack_beat(OP_ALLOC, 16'h0000, 3'd0, 8'd0, 5'd0));
    send_beat(pack_beat(OP_ALLOC, 16'hFFFF, 3'd7, 8'd10, 5'd0));    // same source
    for (int k = 2; k < 8; k++)
      send_beat(pack_beat(OP_ALLOC, ORIGIN_W'(k), 3'd1, PRI_W'(100 + k), 5'd0));
    send_beat(pack_beat(OP_ALLOC, 16'h55AA, 3'd2, 8'd200, 5'd0));   // rejected
    send_beat(pack_beat(OP_ALLOC, 16'h55AA, 3'd2, 8'd107, 5'd0));   // equal number evicts
    send_beat(pack_beat(OP_SETPRI, 16'h0000, 3'd0, 8'd150, 5'd3));
    send_beat(pack_beat(OP_SETPRI, 16'h0000, 3'd0, 8'd150, 5'd5));
    send_beat(pack_beat(OP_ALLOC, 16'h2222, 3'd3, 8'd150, 5'd0));   // tie, lowest index
    send_beat(pack_beat(OP_DETACH, 16'hFFFF, 3'd0, 8'd0, 5'd0));
    send_beat(pack_beat(OP_ALLOC, 16'hFFFF, 3'd7, 8'd0, 5'd0));     // detached never matches
    send_beat(pack_beat(OP_STOP, 16'hFFFF, 3'd0, 8'd0, 5'd0));
    send_beat(pack_beat(OP_STOP, 16'hFFFF, 3'd0, 8'd0, 5'd0));
    send_beat(pack_beat(OP_SETPRI, 16'h0000, 3'd0, 8'd1, 5'd31));   // beyond channel count
    send_beat(pack_beat(OP_RELEASE, 16'h0000, 3'd0, 8'd0, 5'd8));
    send_beat(pack_beat(OP_RELEASE, 16'h0000, 3'd0, 8'd0, 5'd1));
    send_beat(pack_beat(OP_BAD6, 16'h1234, 3'd4, 8'd4, 5'd4));
    send_beat(pack_beat(OP_BAD7, 16'h4321, 3'd5, 8'd5, 5'd5));
    send_beat(pack_beat(OP_CLEAR, 16'h0000, 3'd0, 8'd0, 5'd0));

    // Random: channel counts incl. zero, saturation and effects off
    run_phase(8,  1'b1, 0,  0,  150);
    run_phase(32, 1'b1, 53, 0,  150);
    run_phase(1,  1'b1, 0,  53, 100);
    run_phase(63, 1'b1, 32, 32, 150);
    run_phase(0,  1'b1, 0,  0,  40);
    run_phase(32, 1'b0, 53, 0,  60);
    run_phase(5,  1'b1, 0,  53, 150);
    run_phase(20, 1'b1, 32, 32, 150);
    run_phase(32, 1'b1, 0,  0,  100);

    wait_idle();
    $display("Covered %0d request beats across %0d register settings, %0d results checked",
             beats_sent, settings_run, results_seen);
    $display("Channel counts 0 to 63 with effects on and off, sender and receiver idling");
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sound_voice_allocator.f @@
src/sva_pkg.sv
src/sva_scan.sv
src/sound_voice_allocator.sv
sim/sva_checker.sv
sim/tb_sound_voice_allocator.sv
